@@ hw/rtl/pxmc_pkg.sv @@
// ----------------------------------------------------------------------------
// pxmc_pkg
// Shared constants and controller/datapath interface types of the prefix XOR
// match counter.
// ----------------------------------------------------------------------------
package pxmc_pkg;

   // request and response field widths
   localparam int IN_IDX_W   = 8;
   localparam int IN_VAL_W   = 8;
   localparam int OUT_CNT_W  = 9;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 16;

   // operation codes carried on tuser
   localparam logic OP_SET   = 1'b0;
   localparam logic OP_COUNT = 1'b1;

   // parameter defaults
   localparam int DEF_NUM_ELEMENTS = 256;
   localparam int DEF_BLOCK_SIZE   = 16;
   localparam int DEF_VALUE_BITS   = 8;

   // commands from the controller to the datapath
   typedef struct packed {
      logic capture;    // take the request fields
      logic clr_step;   // write reset values at the sweep address
      logic set_div;    // find the block of the write position
      logic set_base;   // find the last position of that block
      logic set_delta;  // store the element, latch the XOR change
      logic upd_pfx;    // repair one prefix, read the old count
      logic upd_dec;    // decrement old count, read the new count
      logic upd_inc;    // increment new count, advance
      logic q_look;     // read the prefix that closes the previous block
      logic q_fix;      // fold it into the key, read the block count
      logic q_acc;      // add the block count, step to the next block
      logic scan_cmp;   // compare one tail prefix, advance
      logic out_load;   // load the response register
   } cmd_type;

   // status from the datapath to the controller
   typedef struct packed {
      logic req_query;   // incoming request is a count
      logic req_set_ok;  // incoming request is a write inside the array
      logic clr_done;    // sweep address at its last entry
      logic delta_zero;  // write leaves the element unchanged
      logic upd_last;    // repair position at the end of its block
      logic whole;       // a whole block fits below the query position
      logic p_le_pos;    // tail not exhausted
      logic p_eq_pos;    // tail position is the query position
   } sts_type;

endpackage

@@ hw/rtl/pxmc_ram.sv @@
// ----------------------------------------------------------------------------
// pxmc_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module pxmc_ram #(
   parameter int DATA_W = 8,
   parameter int DEPTH  = 256,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [DATA_W-1:0] wr_data,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [DATA_W-1:0] rd_data
);

   logic [DATA_W-1:0] mem_ff [DEPTH];
   logic [DATA_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

@@ hw/rtl/pxmc_datapath.sv @@
// ----------------------------------------------------------------------------
// pxmc_datapath
// Element, prefix and count memories with the position, key and total
// registers that the controller steps through them.
// ----------------------------------------------------------------------------
module pxmc_datapath #(
   parameter int NUM_ELEMENTS = pxmc_pkg::DEF_NUM_ELEMENTS,
   parameter int BLOCK_SIZE   = pxmc_pkg::DEF_BLOCK_SIZE,
   parameter int VALUE_BITS   = pxmc_pkg::DEF_VALUE_BITS
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic [pxmc_pkg::REQ_DATA_W-1:0]     req_tdata,
   input  logic                                req_tuser,
   input  pxmc_pkg::cmd_type                   cmd,
   output pxmc_pkg::sts_type                   sts,
   output logic [pxmc_pkg::RSP_DATA_W-1:0]     rsp_tdata
);

   import pxmc_pkg::*;

   localparam int VB          = VALUE_BITS;
   localparam int IDX_W       = $clog2(NUM_ELEMENTS);
   localparam int POS_W       = $clog2(NUM_ELEMENTS + 1);
   localparam int NUM_BLOCKS  = (NUM_ELEMENTS + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int BLK_W       = (NUM_BLOCKS > 1) ? $clog2(NUM_BLOCKS) : 1;
   localparam int BLKC_W      = $clog2(NUM_BLOCKS + 1);
   localparam int CNT_W       = $clog2(BLOCK_SIZE + 1);
   localparam int CNT_AW      = BLK_W + VB;
   localparam int CNT_DEPTH   = NUM_BLOCKS * (1 << VB);
   localparam int CLR_DEPTH   = (CNT_DEPTH > NUM_ELEMENTS) ? CNT_DEPTH : NUM_ELEMENTS;
   localparam int CLR_W       = $clog2(CLR_DEPTH);
   localparam int TOT_W       = $clog2(NUM_ELEMENTS + 1);
   localparam int LAST_LEN    = NUM_ELEMENTS - (NUM_BLOCKS - 1) * BLOCK_SIZE;
   localparam int RECIP_SHIFT = IN_IDX_W + $clog2(BLOCK_SIZE);
   localparam int RECIP       = ((1 << RECIP_SHIFT) + BLOCK_SIZE - 1) / BLOCK_SIZE;
   localparam int RECIP_W     = RECIP_SHIFT + 1;
   localparam int PROD_W      = IN_IDX_W + RECIP_W;

   // request fields
   logic [IN_IDX_W-1:0] req_idx;
   logic [IN_VAL_W-1:0] req_val;
   logic                req_in_range;

   // registers
   logic [IN_IDX_W-1:0]  idx_ff,   idx_in;
   logic [VB-1:0]        val_ff,   val_in;
   logic [POS_W-1:0]     pos_ff,   pos_in;
   logic [POS_W-1:0]     p_ff,     p_in;
   logic [POS_W-1:0]     last_ff,  last_in;
   logic [BLKC_W-1:0]    blk_ff,   blk_in;
   logic [VB-1:0]        delta_ff, delta_in;
   logic [VB-1:0]        old_ff,   old_in;
   logic [VB-1:0]        new_ff,   new_in;
   logic [VB-1:0]        want_ff,  want_in;
   logic [TOT_W-1:0]     total_ff, total_in;
   logic [OUT_CNT_W-1:0] match_ff, match_in;
   logic [CLR_W-1:0]     clr_ff,   clr_in;

   // memory ports
   logic             elem_we, pfx_we, cnt_we;
   logic [IDX_W-1:0] elem_waddr, pfx_waddr, pfx_raddr;
   logic [VB-1:0]    elem_wdata, pfx_wdata, elem_rdata, pfx_rdata;
   logic [CNT_AW-1:0] cnt_waddr, cnt_raddr;
   logic [CNT_W-1:0]  cnt_wdata, cnt_rdata;

   // helpers
   logic              p_zero;
   logic [VB-1:0]     want_next;
   logic [VB-1:0]     new_v;
   logic [PROD_W-1:0] div_prod;
   logic [BLKC_W-1:0] blk_div;
   int                end_v;
   logic [POS_W-1:0]  last_v;
   logic [POS_W-1:0]  pfx_rd_pos;
   logic [BLK_W-1:0]  row;
   logic              clr_elem, clr_cnt;
   logic [CNT_AW-1:0] clr_caddr;
   logic [CNT_W-1:0]  clr_cval;

   assign req_idx      = req_tdata[IN_IDX_W-1:0];
   assign req_val      = req_tdata[IN_IDX_W+IN_VAL_W-1:IN_IDX_W];
   assign req_in_range = 32'(req_idx) < NUM_ELEMENTS;

   assign p_zero    = (p_ff == '0);
   assign want_next = want_ff ^ (p_zero ? '0 : pfx_rdata);
   assign new_v     = pfx_rdata ^ delta_ff;
   assign row       = blk_ff[BLK_W-1:0];

   // block number by reciprocal multiply, exact for 8-bit positions
   assign div_prod = PROD_W'(idx_ff) * PROD_W'(RECIP);
   assign blk_div  = BLKC_W'(div_prod >> RECIP_SHIFT);

   always_comb begin
      end_v  = (int'(blk_ff) + 1) * BLOCK_SIZE;
      last_v = POS_W'(((end_v > NUM_ELEMENTS) ? NUM_ELEMENTS : end_v) - 1);
   end

   // reset sweep values
   assign clr_elem  = cmd.clr_step && (32'(clr_ff) < NUM_ELEMENTS);
   assign clr_cnt   = cmd.clr_step && (32'(clr_ff) < CNT_DEPTH);
   assign clr_caddr = CNT_AW'(clr_ff);
   always_comb begin
      clr_cval = '0;
      if (clr_caddr[VB-1:0] == '0) begin
         clr_cval = (clr_caddr[CNT_AW-1:VB] == BLK_W'(NUM_BLOCKS - 1)) ?
                    CNT_W'(LAST_LEN) : CNT_W'(BLOCK_SIZE);
      end
   end

   // element store
   assign elem_we    = clr_elem || cmd.set_delta;
   assign elem_waddr = cmd.clr_step ? IDX_W'(clr_ff) : pos_ff[IDX_W-1:0];
   assign elem_wdata = cmd.clr_step ? '0 : val_ff;

   // block-local prefix store
   assign pfx_we    = clr_elem || cmd.upd_pfx;
   assign pfx_waddr = cmd.clr_step ? IDX_W'(clr_ff) : p_ff[IDX_W-1:0];
   assign pfx_wdata = cmd.clr_step ? '0 : new_v;
   always_comb begin
      pfx_rd_pos = p_ff;
      if (cmd.q_look) begin
         pfx_rd_pos = p_ff - POS_W'(1);
      end else if (cmd.upd_inc) begin
         pfx_rd_pos = p_ff + POS_W'(1);
      end
   end
   assign pfx_raddr = pfx_rd_pos[IDX_W-1:0];

   // per-block count table
   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = clr_caddr;
      cnt_wdata = clr_cval;
      if (cmd.clr_step) begin
         cnt_we = clr_cnt;
      end else if (cmd.upd_dec) begin
         cnt_we    = 1'b1;
         cnt_waddr = {row, old_ff};
         cnt_wdata = cnt_rdata - CNT_W'(1);
      end else if (cmd.upd_inc) begin
         cnt_we    = 1'b1;
         cnt_waddr = {row, new_ff};
         cnt_wdata = cnt_rdata + CNT_W'(1);
      end
   end

   always_comb begin
      if (cmd.upd_pfx) begin
         cnt_raddr = {row, pfx_rdata};
      end else if (cmd.upd_dec) begin
         cnt_raddr = {row, new_ff};
      end else begin
         cnt_raddr = {row, want_next};
      end
   end

   pxmc_ram #(.DATA_W(VB), .DEPTH(NUM_ELEMENTS)) u_elem_ram (
      .clock   (clock),
      .wr_en   (elem_we),
      .wr_addr (elem_waddr),
      .wr_data (elem_wdata),
      .rd_addr (pos_ff[IDX_W-1:0]),
      .rd_data (elem_rdata)
   );

   pxmc_ram #(.DATA_W(VB), .DEPTH(NUM_ELEMENTS)) u_pfx_ram (
      .clock   (clock),
      .wr_en   (pfx_we),
      .wr_addr (pfx_waddr),
      .wr_data (pfx_wdata),
      .rd_addr (pfx_raddr),
      .rd_data (pfx_rdata)
   );

   pxmc_ram #(.DATA_W(CNT_W), .DEPTH(1 << CNT_AW)) u_cnt_ram (
      .clock   (clock),
      .wr_en   (cnt_we),
      .wr_addr (cnt_waddr),
      .wr_data (cnt_wdata),
      .rd_addr (cnt_raddr),
      .rd_data (cnt_rdata)
   );

   // register next values
   always_comb begin
      idx_in   = idx_ff;
      val_in   = val_ff;
      pos_in   = pos_ff;
      p_in     = p_ff;
      last_in  = last_ff;
      blk_in   = blk_ff;
      delta_in = delta_ff;
      old_in   = old_ff;
      new_in   = new_ff;
      want_in  = want_ff;
      total_in = total_ff;
      match_in = match_ff;
      clr_in   = cmd.clr_step ? clr_ff + CLR_W'(1) : clr_ff;

      if (cmd.capture) begin
         idx_in   = req_idx;
         val_in   = VB'(req_val);
         want_in  = VB'(req_val);
         pos_in   = req_in_range ? POS_W'(req_idx) : POS_W'(NUM_ELEMENTS - 1);
         p_in     = '0;
         blk_in   = '0;
         total_in = '0;
      end
      if (cmd.set_div) begin
         blk_in = blk_div;
         p_in   = pos_ff;
      end
      if (cmd.set_base) begin
         last_in = last_v;
      end
      if (cmd.set_delta) begin
         delta_in = elem_rdata ^ val_ff;
      end
      if (cmd.upd_pfx) begin
         old_in = pfx_rdata;
         new_in = new_v;
      end
      if (cmd.upd_inc) begin
         p_in = p_ff + POS_W'(1);
      end
      if (cmd.q_fix) begin
         want_in = want_next;
      end
      if (cmd.q_acc) begin
         total_in = total_ff + TOT_W'(cnt_rdata);
         p_in     = POS_W'(32'(p_ff) + BLOCK_SIZE);
         blk_in   = blk_ff + BLKC_W'(1);
      end
      if (cmd.scan_cmp) begin
         if (pfx_rdata == want_ff) begin
            total_in = total_ff + TOT_W'(1);
         end
         p_in = p_ff + POS_W'(1);
      end
      if (cmd.out_load) begin
         match_in = OUT_CNT_W'(total_ff);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff <= '0;
      end else begin
         clr_ff <= clr_in;
      end
      idx_ff   <= idx_in;
      val_ff   <= val_in;
      pos_ff   <= pos_in;
      p_ff     <= p_in;
      last_ff  <= last_in;
      blk_ff   <= blk_in;
      delta_ff <= delta_in;
      old_ff   <= old_in;
      new_ff   <= new_in;
      want_ff  <= want_in;
      total_ff <= total_in;
      match_ff <= match_in;
   end

   // status
   assign sts.req_query  = (req_tuser == OP_COUNT);
   assign sts.req_set_ok = (req_tuser == OP_SET) && req_in_range;
   assign sts.clr_done   = (32'(clr_ff) == CLR_DEPTH - 1);
   assign sts.delta_zero = ((elem_rdata ^ val_ff) == '0);
   assign sts.upd_last   = (p_ff == last_ff);
   assign sts.whole      = (32'(p_ff) + BLOCK_SIZE) <= (32'(pos_ff) + 1);
   assign sts.p_le_pos   = (p_ff <= pos_ff);
   assign sts.p_eq_pos   = (p_ff == pos_ff);

   assign rsp_tdata = RSP_DATA_W'(match_ff);

endmodule

@@ hw/rtl/pxmc_ctrl.sv @@
// ----------------------------------------------------------------------------
// pxmc_ctrl
// Sequencer for the reset sweep, the write repair loop and the query walk;
// owns the request and response handshakes.
// ----------------------------------------------------------------------------
module pxmc_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  pxmc_pkg::sts_type sts,
   output pxmc_pkg::cmd_type cmd
);

   import pxmc_pkg::*;

   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_SET_DIV,
      ST_SET_BASE,
      ST_SET_DELTA,
      ST_UPD_PFX,
      ST_UPD_DEC,
      ST_UPD_INC,
      ST_Q_LOOK,
      ST_Q_FIX,
      ST_Q_ACC,
      ST_SCAN_RD,
      ST_SCAN_CMP,
      ST_Q_OUT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_tvalid_ff, rsp_tvalid_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_CLEAR: begin
            cmd.clr_step = 1'b1;
            if (sts.clr_done) begin
               state_in = ST_IDLE;
            end
         end
         ST_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               if (sts.req_query) begin
                  state_in = ST_Q_LOOK;
               end else if (sts.req_set_ok) begin
                  state_in = ST_SET_DIV;
               end
            end
         end
         ST_SET_DIV: begin
            cmd.set_div = 1'b1;
            state_in    = ST_SET_BASE;
         end
         ST_SET_BASE: begin
            cmd.set_base = 1'b1;
            state_in     = ST_SET_DELTA;
         end
         ST_SET_DELTA: begin
            cmd.set_delta = 1'b1;
            state_in      = sts.delta_zero ? ST_IDLE : ST_UPD_PFX;
         end
         ST_UPD_PFX: begin
            cmd.upd_pfx = 1'b1;
            state_in    = ST_UPD_DEC;
         end
         ST_UPD_DEC: begin
            cmd.upd_dec = 1'b1;
            state_in    = ST_UPD_INC;
         end
         ST_UPD_INC: begin
            cmd.upd_inc = 1'b1;
            state_in    = sts.upd_last ? ST_IDLE : ST_UPD_PFX;
         end
         ST_Q_LOOK: begin
            cmd.q_look = 1'b1;
            state_in   = ST_Q_FIX;
         end
         ST_Q_FIX: begin
            cmd.q_fix = 1'b1;
            if (sts.whole) begin
               state_in = ST_Q_ACC;
            end else if (sts.p_le_pos) begin
               state_in = ST_SCAN_RD;
            end else begin
               state_in = ST_Q_OUT;
            end
         end
         ST_Q_ACC: begin
            cmd.q_acc = 1'b1;
            state_in  = ST_Q_LOOK;
         end
         ST_SCAN_RD: begin
            state_in = ST_SCAN_CMP;
         end
         ST_SCAN_CMP: begin
            cmd.scan_cmp = 1'b1;
            state_in     = sts.p_eq_pos ? ST_Q_OUT : ST_SCAN_RD;
         end
         ST_Q_OUT: begin
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      if (cmd.out_load) begin
         rsp_tvalid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_CLEAR;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   assign req_tready = (state_ff == ST_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

endmodule

@@ hw/rtl/prefix_xor_match_counter.sv @@
// ----------------------------------------------------------------------------
// prefix_xor_match_counter
// Square-root decomposed array answering "how many prefix XORs up to a
// position equal a key", with single-element writes.
// ----------------------------------------------------------------------------
// The array holds NUM_ELEMENTS values split into blocks of BLOCK_SIZE. Each
// position keeps the XOR of its block up to itself, and each block keeps a
// table counting how many of its positions hold each such value. A write
// request (tuser = set) stores one element and repairs prefixes and counts to
// the end of its block: a setup that finds the block and its end and stores
// the element, then per repaired position a read of the old count, its write
// old-1 with a read of the new count, and the write new+1, bound by the single
// read port of the count memory. A write that leaves the element unchanged
// finishes after setup; a write beyond the array is dropped. A count request
// walks the whole blocks below the position, each with a prefix read, a count
// read and an accumulate, then scans the trailing partial block with a read
// and a compare per position. A count beyond the array counts over the whole
// array. One request is worked at a time; a new request is taken while the
// previous response still waits in the output register. After reset the
// block sweeps its memories to their reset contents, one entry per cycle over
// max(NUM_BLOCKS * 2^VALUE_BITS, NUM_ELEMENTS) entries (4096 at the
// defaults), and holds req_tready low meanwhile.
// ----------------------------------------------------------------------------
module prefix_xor_match_counter #(
   parameter int NUM_ELEMENTS = pxmc_pkg::DEF_NUM_ELEMENTS,
   parameter int BLOCK_SIZE   = pxmc_pkg::DEF_BLOCK_SIZE,
   parameter int VALUE_BITS   = pxmc_pkg::DEF_VALUE_BITS
) (
   input  logic                            clock,
   input  logic                            reset,
   // request channel
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [pxmc_pkg::REQ_DATA_W-1:0] req_tdata,   // [7:0] index, [15:8] value
   input  logic                            req_tuser,   // [0] operation
   // response channel
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [pxmc_pkg::RSP_DATA_W-1:0] rsp_tdata    // [8:0] match_count, rest zero
);

   import pxmc_pkg::*;

   cmd_type cmd;
   sts_type sts;

   // sequencer: handshakes, reset sweep, repair and query walks
   pxmc_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // memories and working registers
   pxmc_datapath #(
      .NUM_ELEMENTS (NUM_ELEMENTS),
      .BLOCK_SIZE   (BLOCK_SIZE),
      .VALUE_BITS   (VALUE_BITS)
   ) u_datapath (
      .clock     (clock),
      .reset     (reset),
      .req_tdata (req_tdata),
      .req_tuser (req_tuser),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_tdata (rsp_tdata)
   );

endmodule

@@ hw/rtl/pxmc_checker.sv @@
// ----------------------------------------------------------------------------
// pxmc_checker
// Port-level checks of the prefix XOR match counter, bound to the top level.
// ----------------------------------------------------------------------------
module pxmc_checker #(
   parameter int NUM_ELEMENTS = pxmc_pkg::DEF_NUM_ELEMENTS
) (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            req_tuser,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [pxmc_pkg::RSP_DATA_W-1:0] rsp_tdata
);

   import pxmc_pkg::*;

   // no response survives reset
   a_reset_clears_rsp: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // a stalled response holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // a count never exceeds the array size
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (NUM_ELEMENTS > 511) ||
                     (32'(rsp_tdata[OUT_CNT_W-1:0]) <= NUM_ELEMENTS))
      else $error("match count above array size");

   // padding above the count stays zero
   a_rsp_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> (rsp_tdata[RSP_DATA_W-1:OUT_CNT_W] == '0))
      else $error("response padding not zero");

   // a taken count request leaves the block busy, with req_tready low
   a_query_busy: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready && (req_tuser == OP_COUNT) |=> !req_tready)
      else $error("ready right after a count request");

endmodule

bind prefix_xor_match_counter pxmc_checker #(
   .NUM_ELEMENTS (NUM_ELEMENTS)
) u_pxmc_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .req_tuser  (req_tuser),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
